### design/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg: text mode console writer shared definitions
// Payload structs, operation codes, character constants and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned CELL_W      = 16;
  localparam int unsigned ROW_FIELD_W = 5;
  localparam int unsigned COL_FIELD_W = 7;

  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_col;
  } in_t;

  typedef struct packed {
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_col;
    logic [CELL_W-1:0]      cell_value;
    logic                   scrolled;
  } out_t;

  typedef enum logic [2:0] {
    SW_NONE,
    SW_RESET,
    SW_FILL,
    SW_COPY,
    SW_BLANK
  } sweep_e;

  typedef struct packed {
    logic   load_in;
    logic   exec;
    logic   issue_read;
    logic   prime_read;
    logic   load_out;
    sweep_e sweep;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scroll_needed;
    logic            sweep_last;
    logic            copy_last;
  } ctrl_sts_t;

endpackage

### design/tmcw_ram.sv
// ----------------------------------------------------------------------------
// tmcw_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tmcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// tmcw_ctrl: text mode console writer controller
// Sequences the reset clear, accept, execute, cell read, fill, scroll sweeps and
// result transfer; drives the datapath through a command bundle.
// ----------------------------------------------------------------------------
module tmcw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tmcw_pkg::ctrl_sts_t sts_i,
  output tmcw_pkg::ctrl_cmd_t cmd_o
);
  import tmcw_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_SCROLL_PRIME,
    ST_SCROLL_COPY,
    ST_SCROLL_BLANK,
    ST_FINISH
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  logic      finish_req;
  ctrl_cmd_t cmd;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    finish_req     = 1'b0;
    cmd.load_in    = 1'b0;
    cmd.exec       = 1'b0;
    cmd.issue_read = 1'b0;
    cmd.prime_read = 1'b0;
    cmd.load_out   = 1'b0;
    cmd.sweep      = SW_NONE;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.sweep = SW_RESET;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts_i.op) inside
          OP_WRITE: begin
            if (sts_i.scroll_needed) begin
              state_d = ST_SCROLL_PRIME;
            end else begin
              finish_req = 1'b1;
            end
          end
          OP_CLEAR, OP_FILL: begin
            state_d = ST_FILL;
          end
          OP_READ: begin
            cmd.issue_read = 1'b1;
            state_d        = ST_READ;
          end
          default: begin
            finish_req = 1'b1;
          end
        endcase
      end
      ST_READ: begin
        finish_req = 1'b1;
      end
      ST_FILL: begin
        cmd.sweep = SW_FILL;
        if (sts_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_SCROLL_PRIME: begin
        cmd.prime_read = 1'b1;
        state_d        = ST_SCROLL_COPY;
      end
      ST_SCROLL_COPY: begin
        cmd.sweep = SW_COPY;
        if (sts_i.copy_last) begin
          state_d = ST_SCROLL_BLANK;
        end
      end
      ST_SCROLL_BLANK: begin
        cmd.sweep = SW_BLANK;
        if (sts_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        finish_req = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (finish_req) begin
      if (out_free) begin
        cmd.load_out = 1'b1;
        state_d      = ST_IDLE;
      end else begin
        state_d = ST_FINISH;
      end
    end
    out_valid_d = cmd.load_out || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending transfer");

  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> (state_q != ST_EXEC))
    else $error("execute step repeated");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted item not executed");
`endif

endmodule

### design/tmcw_datapath.sv
// ----------------------------------------------------------------------------
// tmcw_datapath: text mode console writer datapath
// Cursor, colour register, sweep counter, cell store and result register.
// ----------------------------------------------------------------------------
module tmcw_datapath #(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  tmcw_pkg::in_t       in_data_i,
  input  tmcw_pkg::ctrl_cmd_t cmd_i,
  output tmcw_pkg::ctrl_sts_t sts_o,
  output tmcw_pkg::out_t      out_data_o
);
  import tmcw_pkg::*;

  localparam int unsigned CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int unsigned LAST  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(SCREEN_ROWS);
  localparam int unsigned CW    = $clog2(SCREEN_COLUMNS);

  localparam logic [RW-1:0] ROW_MAX   = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] COL_MAX   = CW'(SCREEN_COLUMNS - 1);
  localparam logic [AW-1:0] SWEEP_END = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(LAST - 1);

  in_t               in_q;
  out_t              out_q, out_d;
  logic [ATTR_W-1:0] attr_q;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic              scrolled_q, scrolled_d;
  logic [AW-1:0]     cnt_q, cnt_d;

  logic              is_nl, at_last_col, at_last_row, line_end;
  logic              in_range;
  logic              cell_we;
  logic [CW-1:0]     cell_col;
  logic [CELL_W-1:0] cell_data;
  logic [AW-1:0]     cur_addr, rd_cell_addr, copy_src;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign is_nl       = (in_q.char_code == NEWLINE_CODE);
  assign at_last_col = (col_q == COL_MAX);
  assign at_last_row = (row_q == ROW_MAX);
  assign line_end    = is_nl || at_last_col;
  assign in_range    = (32'(in_q.read_row) < SCREEN_ROWS) &&
                       (32'(in_q.read_col) < SCREEN_COLUMNS);

  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    scrolled_d = scrolled_q;
    cell_we    = 1'b0;
    cell_col   = col_q;
    cell_data  = {attr_q, in_q.char_code};
    if (cmd_i.exec) begin
      scrolled_d = 1'b0;
      unique case (in_q.operation)
        OP_WRITE: begin
          cell_we = !is_nl;
          if (line_end) begin
            col_d = '0;
            if (at_last_row) begin
              scrolled_d = 1'b1;
            end else begin
              row_d = row_q + RW'(1);
            end
          end else begin
            col_d = col_q + CW'(1);
          end
        end
        OP_DELETE: begin
          if (col_q != '0) begin
            col_d     = col_q - CW'(1);
            cell_col  = col_q - CW'(1);
            cell_we   = 1'b1;
            cell_data = {attr_q, SPACE_CODE};
          end
        end
        OP_CLEAR: begin
          row_d = '0;
          col_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign cur_addr     = AW'(32'(row_q) * SCREEN_COLUMNS + 32'(cell_col));
  assign rd_cell_addr = AW'(32'(in_q.read_row) * SCREEN_COLUMNS + 32'(in_q.read_col));
  assign copy_src     = AW'(32'(cnt_q) + SCREEN_COLUMNS + 32'd1);

  always_comb begin
    ram_we    = cell_we;
    ram_waddr = cur_addr;
    ram_wdata = cell_data;
    ram_re    = cmd_i.issue_read && in_range;
    ram_raddr = rd_cell_addr;
    if (cmd_i.prime_read) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(SCREEN_COLUMNS);
    end
    case (cmd_i.sweep) inside
      SW_RESET: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {RESET_ATTR, SPACE_CODE};
      end
      SW_FILL, SW_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {attr_q, SPACE_CODE};
      end
      SW_COPY: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = ram_rdata;
        ram_re    = (cnt_q != COPY_END);
        ram_raddr = copy_src;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.exec) begin
      cnt_d = '0;
    end else if (cmd_i.sweep != SW_NONE) begin
      cnt_d = cnt_q + AW'(1);
    end
  end

  always_comb begin
    out_d.cursor_row = ROW_FIELD_W'(row_d);
    out_d.cursor_col = COL_FIELD_W'(col_d);
    out_d.cell_value = ((in_q.operation == OP_READ) && in_range) ? ram_rdata : '0;
    out_d.scrolled   = scrolled_d;
  end

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q     <= RESET_ATTR;
      row_q      <= '0;
      col_q      <= '0;
      scrolled_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      row_q      <= row_d;
      col_q      <= col_d;
      scrolled_q <= scrolled_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign sts_o.op            = in_q.operation;
  assign sts_o.scroll_needed = (in_q.operation == OP_WRITE) && line_end && at_last_row;
  assign sts_o.sweep_last    = (cnt_q == SWEEP_END);
  assign sts_o.copy_last     = (cnt_q == COPY_END);
  assign out_data_o          = out_q;

`ifndef NO_ASSERTIONS
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < SCREEN_ROWS)
    else $error("cursor row off screen");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < SCREEN_COLUMNS)
    else $error("cursor column off screen");

  a_scroll_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scrolled_q |-> (row_q == ROW_MAX && col_q == '0))
    else $error("scroll flagged away from bottom row start");
`endif

endmodule

### design/text_mode_console_writer.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer: text console engine over a cell store
// Each item is one console operation and yields one result transfer. A
// character write, newline, delete or unused code and a cell read finish
// without a sweep; fill, clear and a write that scrolls sweep the cell RAM,
// which takes one write a cycle, so every sweep moves one cell per cycle.
// After reset a clearing pass blanks the store before the first item is
// taken; colour writes are taken throughout. A finished result waits in an
// output register while the next item enters.
// ----------------------------------------------------------------------------
module text_mode_console_writer #(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tmcw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tmcw_pkg::out_t out_data_o
);
  import tmcw_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tmcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tmcw_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/tb_text_mode_console_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_mode_console_writer: regression for the text console engine
// Sends directed and random console commands over valid/ready with random
// stalls on both sides. A shadow screen predicts the cursor, the scroll flag
// and cell reads, and every result transfer is checked in order. The colour
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_text_mode_console_writer;
  import tmcw_pkg::*;

  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned CYCLE_CAP   = 8_000_000;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned PHASES      = 6;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [ROWS*COLUMNS];
    int unsigned       row;
    int unsigned       col;
    logic [ATTR_W-1:0] colour;
    out_t              due_results[$];
    int unsigned       errors;

    function new();
      colour = RESET_ATTR;
      row    = 0;
      col    = 0;
      errors = 0;
      blank_screen();
    endfunction

    function void blank_screen();
      foreach (screen[i]) screen[i] = {colour, SPACE_CODE};
    endfunction

    function bit next_line();
      col = 0;
      if (row < ROWS - 1) begin
        row++;
        return 1'b0;
      end
      for (int unsigned i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int unsigned i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++) begin
        screen[i] = {colour, SPACE_CODE};
      end
      return 1'b1;
    endfunction

    function void apply_command(in_t cmd);
      out_t res;
      res = '0;
      case (cmd.operation)
        OP_WRITE: begin
          if (cmd.char_code == NEWLINE_CODE) begin
            res.scrolled = next_line();
          end else begin
            screen[row * COLUMNS + col] = {colour, cmd.char_code};
            col++;
            if (col >= COLUMNS) res.scrolled = next_line();
          end
        end
        OP_DELETE: begin
          if (col > 0) begin
            col--;
            screen[row * COLUMNS + col] = {colour, SPACE_CODE};
          end
        end
        OP_CLEAR: begin
          blank_screen();
          row = 0;
          col = 0;
        end
        OP_FILL: begin
          blank_screen();
        end
        OP_READ: begin
          if (cmd.read_row < ROWS && cmd.read_col < COLUMNS) begin
            res.cell_value = screen[cmd.read_row * COLUMNS + cmd.read_col];
          end
        end
        default: begin
        end
      endcase
      res.cursor_row = row[ROW_FIELD_W-1:0];
      res.cursor_col = col[COL_FIELD_W-1:0];
      due_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(got.cursor_row));
      compare_field("cursor_col", CELL_W'(want.cursor_col), CELL_W'(got.cursor_col));
      compare_field("cell_value", want.cell_value, got.cell_value);
      compare_field("scrolled", CELL_W'(want.scrolled), CELL_W'(got.scrolled));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  out_t        out_data_o;
  bit          calm;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  console_scoreboard sb;

  text_mode_console_writer #(
    .SCREEN_COLUMNS(COLUMNS),
    .SCREEN_ROWS   (ROWS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("text_mode_console_writer regression: fail");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && !calm && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_FIELD_W-1:0] rr, input logic [COL_FIELD_W-1:0] rc);
    in_t item;
    item.operation = op;
    item.char_code = ch;
    item.read_row  = rr;
    item.read_col  = rc;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.apply_command(item);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_colour(input logic [ATTR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.colour = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    send_item(OP_WRITE, 8'h00, 5'd31, 7'd127);
    send_item(OP_WRITE, 8'hFF, 5'd0, 7'd0);
    send_item(OP_READ, 8'hFF, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd1);
    send_item(OP_DELETE, 8'hFF, 5'd31, 7'd127);
    send_item(OP_READ, 8'h00, 5'd0, 7'd1);
    send_item(OP_WRITE, NEWLINE_CODE, 5'd0, 7'd0);
    // delete at column zero stays on the row
    send_item(OP_DELETE, 8'h00, 5'd0, 7'd0);
    send_item(OP_WRITE, 8'h41, 5'd31, 7'd127);
    send_item(OP_READ, 8'h00, 5'd24, 7'd79);
    send_item(OP_READ, 8'h00, 5'd25, 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'd80);
    send_item(OP_READ, 8'hFF, 5'd31, 7'd127);
    send_item(3'd5, 8'hFF, 5'd31, 7'd127);
    send_item(3'd6, 8'h00, 5'd0, 7'd0);
    send_item(3'd7, NEWLINE_CODE, 5'd1, 7'd1);
    send_item(OP_FILL, 8'h41, 5'd1, 7'd0);
    send_item(OP_READ, 8'h00, 5'd1, 7'd0);
    send_item(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'd1, 7'd0);
    send_item(OP_WRITE, 8'h7E, 5'd16, 7'd64);
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned first;
    int unsigned len;
    int unsigned pick;
    logic [ROW_FIELD_W-1:0] rr;
    logic [COL_FIELD_W-1:0] rc;
    first = items_sent;
    while (items_sent - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            len = $urandom_range(80, 100);
          end
          2, 3, 4: begin
            len = $urandom_range(13, 79);
          end
          default: begin
            len = $urandom_range(0, 6);
          end
        endcase
        repeat (len) begin
          send_item(OP_WRITE, CHAR_W'($urandom_range(0, 255)),
                    ROW_FIELD_W'($urandom_range(0, 31)),
                    COL_FIELD_W'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 3) != 0) begin
          send_item(OP_WRITE, NEWLINE_CODE, ROW_FIELD_W'($urandom_range(0, 31)),
                    COL_FIELD_W'($urandom_range(0, 127)));
        end
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 8)) begin
          send_item(OP_WRITE, NEWLINE_CODE, ROW_FIELD_W'($urandom_range(0, 31)),
                    COL_FIELD_W'($urandom_range(0, 127)));
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              rr = ROW_FIELD_W'(sb.row - $urandom_range(0, sb.row < 2 ? sb.row : 2));
              rc = COL_FIELD_W'($urandom_range(0, COLUMNS - 1));
            end
            8: begin
              rr = ROW_FIELD_W'($urandom_range(0, 31));
              rc = COL_FIELD_W'($urandom_range(0, 127));
            end
            9: begin
              rr = ROW_FIELD_W'(ROWS - 1);
              rc = COL_FIELD_W'($urandom_range(0, COLUMNS - 1));
            end
            default: begin
              rr = ROW_FIELD_W'($urandom_range(0, ROWS - 1));
              rc = COL_FIELD_W'($urandom_range(0, COLUMNS - 1));
            end
          endcase
          send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), rr, rc);
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 5)) begin
          send_item(OP_DELETE, CHAR_W'($urandom_range(0, 255)),
                    ROW_FIELD_W'($urandom_range(0, 31)),
                    COL_FIELD_W'($urandom_range(0, 127)));
        end
      end else if (pick < 96) begin
        send_item($urandom_range(0, 1) ? OP_CLEAR : OP_FILL, CHAR_W'($urandom_range(0, 255)),
                  ROW_FIELD_W'($urandom_range(0, 31)), COL_FIELD_W'($urandom_range(0, 127)));
      end else begin
        send_item(OP_W'($urandom_range(5, 7)), CHAR_W'($urandom_range(0, 255)),
                  ROW_FIELD_W'($urandom_range(0, 31)), COL_FIELD_W'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] colour_pick;
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      pause_until_drained();
      case (p)
        0: begin
          colour_pick = 8'h00;
        end
        1: begin
          colour_pick = 8'hFF;
        end
        3: begin
          colour_pick = 8'hF0;
        end
        5: begin
          colour_pick = RESET_ATTR;
        end
        default: begin
          colour_pick = ATTR_W'($urandom_range(0, 255));
        end
      endcase
      write_colour(colour_pick);
      calm = (p == PHASES - 1);
      random_phase(PHASE_ITEMS);
    end
    pause_until_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("text_mode_console_writer regression: pass");
    end else begin
      $display("text_mode_console_writer regression: fail");
    end
    $finish;
  end

endmodule
